FILE: rtl/core/srs_pkg.sv
package srs_pkg;

   localparam int MAX_POINTS  = 1024;
   localparam int MAX_SAMPLES = 64;

   localparam int WEIGHT_W   = 16;
   localparam int OFFSET_W   = 16;
   localparam int TARGET_W   = 7;
   localparam int SAMPLE_W   = 10;

   localparam int PT_AW      = $clog2(MAX_POINTS);
   localparam int CNT_W      = PT_AW + 1;
   localparam int TOTAL_W    = WEIGHT_W + PT_AW;
   localparam int N_W        = $clog2(MAX_SAMPLES) + 1;
   // numerator stays below 2 * n * 2^16
   localparam int NUM_W      = N_W + OFFSET_W;
   localparam int NT_W       = NUM_W + TOTAL_W;
   localparam int PROD_W     = TOTAL_W + N_W;

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic [OFFSET_W-1:0] start_offset;
      logic                is_last_weight;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_index;
      logic                is_last_sample;
      logic                zero_weight_error;
   } rsp_type;

   typedef enum logic [2:0] {
      S_LOAD,
      S_NS,
      S_NUM,
      S_NT,
      S_CHECK,
      S_PROD,
      S_CMP,
      S_EMIT
   } state_type;

endpackage

FILE: rtl/core/srs_prefix_ram.sv
module srs_prefix_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 26
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/systematic_resampler_top.sv
// Systematic resampler. Weights are taken one per cycle while req_stall is
// low, and their running prefix sums are written into a 1024-entry prefix
// memory; weights past the 1024th are dropped from store and total. The
// transfer that carries is_last_weight starts emission of
// min(target_count, 64) sample indices, and req_stall stays high until the
// last of them has been transferred (target_count of zero emits nothing and
// returns at once). Each sample is set up in S_NUM, S_NT and S_CHECK (the
// first also in S_NS) and then held in the output register in S_EMIT, and
// each forward step of the walk is a prefix memory read, a multiply by the
// sample count, and the exact cross-multiplied compare. A sample whose walk
// stops on a failed compare still passes through that read and compare; one
// that stops at the last point or on a zero total does not. A run is also
// held by any rsp_stall time. Between restarts the walk steps are at most
// the loaded points minus one, and the walk restarts from index 0 for every
// sample whose position wraps past 1.
// A zero total weight gives index 0 with zero_weight_error set.
module systematic_resampler_top
   import srs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_we,
   input  logic [TARGET_W-1:0] csr_wdata
);

   state_type           state_ff, state_in;
   logic [TARGET_W-1:0] target_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [PT_AW-1:0]    walk_ff, walk_in;
   logic [N_W-1:0]      k_ff, k_in;
   logic [N_W-1:0]      n_ff, n_in;
   logic [OFFSET_W-1:0] s_ff, s_in;
   logic                zero_ff, zero_in;
   logic [NUM_W-1:0]    ns_ff, ns_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [NT_W-1:0]     nt_ff, nt_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   rsp_type             rsp_ff, rsp_in;

   logic                wr_en;
   logic                rd_en;
   logic [TOTAL_W-1:0]  rd_data;
   logic [TOTAL_W-1:0]  sum_total;
   logic                room;
   logic [N_W-1:0]      n_sat;
   logic [NUM_W:0]      num_sum;
   logic [NUM_W:0]      den;
   logic [CNT_W-1:0]    walk_next;
   logic                last_k;

   srs_prefix_ram #(
      .DEPTH (MAX_POINTS),
      .WIDTH (TOTAL_W)
   ) u_prefix_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[PT_AW-1:0]),
      .wr_data (sum_total),
      .rd_en   (rd_en),
      .rd_addr (walk_ff),
      .rd_data (rd_data)
   );

   assign sum_total = total_ff + TOTAL_W'(req_data.weight);
   assign room      = count_ff < CNT_W'(MAX_POINTS);
   assign n_sat     = (N_W'(target_ff) > N_W'(MAX_SAMPLES)) ? N_W'(MAX_SAMPLES)
                                                            : N_W'(target_ff);
   assign num_sum   = (NUM_W+1)'(ns_ff) + (NUM_W+1)'({k_ff, {OFFSET_W{1'b0}}});
   assign den       = (NUM_W+1)'({n_ff, {OFFSET_W{1'b0}}});
   assign walk_next = CNT_W'(walk_ff) + CNT_W'(1);
   assign last_k    = (k_ff + N_W'(1)) == n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_LOAD;
         target_ff <= TARGET_W'(1);
         count_ff  <= '0;
         total_ff  <= '0;
         walk_ff   <= '0;
         k_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            target_ff <= csr_wdata;
         end
         count_ff <= count_in;
         total_ff <= total_in;
         walk_ff  <= walk_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      s_ff    <= s_in;
      zero_ff <= zero_in;
      ns_ff   <= ns_in;
      num_ff  <= num_in;
      nt_ff   <= nt_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      total_in = total_ff;
      walk_in  = walk_ff;
      k_in     = k_ff;
      n_in     = n_ff;
      s_in     = s_ff;
      zero_in  = zero_ff;
      ns_in    = ns_ff;
      num_in   = num_ff;
      nt_in    = nt_ff;
      prod_in  = prod_ff;
      rsp_in   = rsp_ff;
      wr_en    = 1'b0;
      rd_en    = 1'b0;

      unique case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               if (room) begin
                  wr_en    = 1'b1;
                  total_in = sum_total;
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_data.is_last_weight) begin
                  n_in    = n_sat;
                  s_in    = req_data.start_offset;
                  zero_in = room ? (sum_total == '0) : (total_ff == '0);
                  walk_in = '0;
                  k_in    = '0;
                  if (n_sat == '0) begin
                     count_in = '0;
                     total_in = '0;
                  end else begin
                     state_in = S_NS;
                  end
               end
            end
         end
         S_NS: begin
            ns_in    = NUM_W'(n_ff) * NUM_W'(s_ff);
            state_in = S_NUM;
         end
         S_NUM: begin
            // position past 1: fold back and restart the walk
            if (num_sum > den) begin
               num_in  = NUM_W'(num_sum - den);
               walk_in = '0;
            end else begin
               num_in = NUM_W'(num_sum);
            end
            state_in = S_NT;
         end
         S_NT: begin
            nt_in    = NT_W'(num_ff) * NT_W'(total_ff);
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!zero_ff && (walk_next < count_ff)) begin
               rd_en    = 1'b1;
               state_in = S_PROD;
            end else begin
               rsp_in.sample_index      = zero_ff ? '0 : SAMPLE_W'(walk_ff);
               rsp_in.is_last_sample    = last_k;
               rsp_in.zero_weight_error = zero_ff;
               state_in                 = S_EMIT;
            end
         end
         S_PROD: begin
            prod_in  = PROD_W'(rd_data) * PROD_W'(n_ff);
            state_in = S_CMP;
         end
         S_CMP: begin
            if (nt_ff > NT_W'({prod_ff, {OFFSET_W{1'b0}}})) begin
               walk_in  = walk_ff + PT_AW'(1);
               state_in = S_CHECK;
            end else begin
               rsp_in.sample_index      = SAMPLE_W'(walk_ff);
               rsp_in.is_last_sample    = last_k;
               rsp_in.zero_weight_error = zero_ff;
               state_in                 = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_stall) begin
               if (last_k) begin
                  count_in = '0;
                  total_in = '0;
                  walk_in  = '0;
                  k_in     = '0;
                  state_in = S_LOAD;
               end else begin
                  k_in     = k_ff + N_W'(1);
                  state_in = S_NUM;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   assign req_stall = state_ff != S_LOAD;
   assign rsp_valid = state_ff == S_EMIT;
   assign rsp_data  = rsp_ff;

   a_zero_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_weight_error |-> rsp_data.sample_index == '0)
      else $error("zero-weight result with nonzero index");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_LOAD |-> count_ff != '0 && CNT_W'(walk_ff) < count_ff)
      else $error("walk position beyond loaded points");

   a_run_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.is_last_sample
      |=> state_ff == S_LOAD && count_ff == '0 && total_ff == '0)
      else $error("weight set not cleared after final sample");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_LOAD |-> n_ff != '0 && k_ff < n_ff)
      else $error("sample counter out of range");

endmodule
